@@ rtl/itaf_pkg.sv @@
`timescale 1ns / 1ps

package itaf_pkg;

  // Geometry
  localparam int PIXEL_CODES_DEF = 256;
  localparam int LANES           = 8;
  localparam int LANE_W          = 16;
  localparam int PHASES          = 4;
  localparam int PHASE_W         = 2;
  localparam int VEC_USED        = 3;               // vectors 4k..4k+2 per phase
  localparam int VEC_W           = LANES * LANE_W;  // 128
  localparam int HALF_W          = VEC_W / 2;       // 64
  localparam int SEGS            = VEC_USED * 2;    // half-vectors per row
  localparam int SEG_W           = 3;
  localparam int ROW_W           = VEC_USED * VEC_W;
  localparam int BYTES_W         = LANES * 8;
  localparam int PKT_SLOTS       = 2;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Beat index within a result packet
  localparam logic [1:0] BEAT_A0 = 2'd0;
  localparam logic [1:0] BEAT_A1 = 2'd1;
  localparam logic [1:0] BEAT_A2 = 2'd2;

  // Unused vector slot within a phase (4k+3)
  localparam logic [1:0] VEC_SLOT_UNUSED = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  pix0;
    logic [7:0]  pix1;
    logic [7:0]  pix2;
    logic [7:0]  pix3;
    logic        last_group;
    logic [7:0]  entry_pixel;
    logic [3:0]  entry_vector;
    logic        entry_half;
    logic [63:0] entry_data;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic        last_out;
  } out_t;

  // Tag that travels alongside a table read
  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] phase;
    logic               zero;
    logic               last;
  } rd_tag_t;

  // One group's results
  typedef struct packed {
    logic [BYTES_W-1:0] b0;
    logic [BYTES_W-1:0] b1;
    logic [BYTES_W-1:0] b2;
    logic               last;
  } pkt_t;

  // >>4 arithmetic, clamp to 0..255
  function automatic logic [7:0] sat_lane(input logic [LANE_W-1:0] x);
    logic [7:0] r;
    if (x[LANE_W-1]) begin
      r = 8'd0;
    end else if (x[LANE_W-2:12] != '0) begin
      r = 8'hFF;
    end else begin
      r = x[11:4];
    end
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] pack_lanes(
      input logic [LANES-1:0][LANE_W-1:0] acc);
    logic [BYTES_W-1:0] r;
    r = '0;
    for (int i = 0; i < LANES; i++) begin
      r[8*i +: 8] = sat_lane(acc[i]);
    end
    return r;
  endfunction

endpackage

@@ rtl/itaf_table.sv @@
`timescale 1ns / 1ps

module itaf_table #(
  parameter int ROWS   = itaf_pkg::PIXEL_CODES_DEF * itaf_pkg::PHASES,
  parameter int ADDR_W = $clog2(ROWS)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [itaf_pkg::SEGS-1:0]   wr_mask,
  input  logic [itaf_pkg::HALF_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [itaf_pkg::ROW_W-1:0]  rd_data
);

  // One row per (code, phase): three vectors, written a half-vector at a time
  logic [itaf_pkg::ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int s = 0; s < itaf_pkg::SEGS; s++) begin
        if (wr_mask[s]) begin
          mem[wr_addr][s*itaf_pkg::HALF_W +: itaf_pkg::HALF_W] <= wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/itaf_accum.sv @@
`timescale 1ns / 1ps

module itaf_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  itaf_pkg::rd_tag_t          tag,
  input  logic [itaf_pkg::ROW_W-1:0] rd_data,
  output logic                       pkt_valid,
  output itaf_pkg::pkt_t             pkt
);

  localparam int L = itaf_pkg::LANES;
  localparam int W = itaf_pkg::LANE_W;

  logic [L-1:0][W-1:0] a0_r, a1_r, a2_r;
  logic [L-1:0][W-1:0] a0_nxt, a1_nxt, a2_nxt;
  logic [L-1:0][W-1:0] s0, s1, s2;
  logic                end_phase;

  assign end_phase = (tag.phase == itaf_pkg::PHASE_W'(itaf_pkg::PHASES - 1));

  always_comb begin
    logic [W-1:0] v0, v1, v2, base2;
    for (int l = 0; l < L; l++) begin
      v0 = tag.zero ? '0 : rd_data[0*itaf_pkg::VEC_W + l*W +: W];
      v1 = tag.zero ? '0 : rd_data[1*itaf_pkg::VEC_W + l*W +: W];
      v2 = tag.zero ? '0 : rd_data[2*itaf_pkg::VEC_W + l*W +: W];
      base2 = (tag.phase == '0) ? '0 : a2_r[l];
      s0[l] = a0_r[l] + v0;
      s1[l] = a1_r[l] + v1;
      s2[l] = base2 + v2;
    end
  end

  // End of group: A0 out, shift A1->A0, fresh->A1; last group clears.
  always_comb begin
    a0_nxt = a0_r;
    a1_nxt = a1_r;
    a2_nxt = a2_r;
    if (tag.valid) begin
      if (!end_phase) begin
        a0_nxt = s0;
        a1_nxt = s1;
        a2_nxt = s2;
      end else if (tag.last) begin
        a0_nxt = '0;
        a1_nxt = '0;
      end else begin
        a0_nxt = s1;
        a1_nxt = s2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r <= '0;
      a1_r <= '0;
    end else begin
      a0_r <= a0_nxt;
      a1_r <= a1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a2_r <= a2_nxt;
  end

  assign pkt_valid = tag.valid && end_phase;
  assign pkt.b0    = itaf_pkg::pack_lanes(s0);
  assign pkt.b1    = itaf_pkg::pack_lanes(s1);
  assign pkt.b2    = itaf_pkg::pack_lanes(s2);
  assign pkt.last  = tag.last;

endmodule

@@ rtl/itaf_outq.sv @@
`timescale 1ns / 1ps

module itaf_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  itaf_pkg::pkt_t push_pkt,
  output logic           out_valid,
  input  logic           out_stall,
  output itaf_pkg::out_t out_data,
  output logic           pkt_done
);

  itaf_pkg::pkt_t slot_r [itaf_pkg::PKT_SLOTS];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [1:0]     beat_r, beat_nxt;
  itaf_pkg::pkt_t head;
  logic           beat_acc;
  logic           final_beat;

  assign head       = slot_r[rd_ptr_r];
  assign out_valid  = (cnt_r != '0);
  assign beat_acc   = out_valid && !out_stall;
  assign final_beat = head.last ? (beat_r == itaf_pkg::BEAT_A2)
                                : (beat_r == itaf_pkg::BEAT_A0);
  assign pkt_done   = beat_acc && final_beat;

  always_comb begin
    out_data = '0;
    unique case (beat_r)
      itaf_pkg::BEAT_A0: out_data.out_bytes = head.b0;
      itaf_pkg::BEAT_A1: out_data.out_bytes = head.b1;
      itaf_pkg::BEAT_A2: begin
        out_data.out_bytes = head.b2;
        out_data.last_out  = head.last;
      end
      default: out_data.out_bytes = head.b0;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r + 2'(push) - 2'(pkt_done);
    beat_nxt = beat_r;
    if (pkt_done) begin
      beat_nxt = itaf_pkg::BEAT_A0;
    end else if (beat_acc) begin
      beat_nxt = beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
      beat_r   <= itaf_pkg::BEAT_A0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pkt_done) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r  <= cnt_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

@@ rtl/impulse_table_accumulate_filter.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Beat                    | Handshake
// --------+-----+-------------------------+--------------------------------
// in_     | in  | table write or pix group| in_valid & !in_stall
// out_    | out | eight bytes + last flag | out_valid & !out_stall
//
// A pixel group reads one row of the impulse table per phase through the
// table's single read port; a table write uses no read. The next beat
// is taken during a group's last read if a credit is free. Results pass
// the registered table read and the result queue; 1 beat per group, 3 on
// a last group. Reset (synchronous, active low) clears the carried
// accumulators and control; table contents stay undefined until written,
// no clearing pass. out_stall holds the result queue; at most two groups
// are in flight or queued, beyond that in_stall is raised.

module impulse_table_accumulate_filter #(
  parameter int PIXEL_CODES = itaf_pkg::PIXEL_CODES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itaf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output itaf_pkg::out_t out_data
);

  localparam int         CODE_W   = $clog2(PIXEL_CODES);
  localparam int         ROWS     = PIXEL_CODES * itaf_pkg::PHASES;
  localparam int         ADDR_W   = CODE_W + itaf_pkg::PHASE_W;
  localparam logic [8:0] CODE_LIM = 9'(PIXEL_CODES);

  // Sequencer: holds the item being worked, walks phases
  logic                        cur_valid_r;
  itaf_pkg::in_t               cur_r;
  logic [itaf_pkg::PHASE_W-1:0] phase_r;
  logic                        cur_is_pix;
  logic                        cur_done;
  logic                        in_acc;
  logic                        credit_ok;
  logic [1:0]                  tot_r, tot_nxt;
  logic                        pkt_done;

  // Table ports
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [itaf_pkg::SEGS-1:0]   wr_mask;
  logic [itaf_pkg::SEG_W-1:0]  wr_seg;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic [itaf_pkg::ROW_W-1:0]  rd_data;
  logic [7:0]                  pix_sel;
  itaf_pkg::rd_tag_t           tag_r;

  logic                        pkt_valid;
  itaf_pkg::pkt_t              pkt;

  assign cur_is_pix = (cur_r.req_type == itaf_pkg::REQ_PIXEL);
  assign cur_done   = cur_valid_r &&
                      (!cur_is_pix ||
                       phase_r == itaf_pkg::PHASE_W'(itaf_pkg::PHASES - 1));

  // Credits cover groups in flight plus queued result packets
  assign credit_ok = (tot_r < 2'(itaf_pkg::PKT_SLOTS)) || pkt_done;
  assign in_stall  = !((!cur_valid_r || cur_done) && credit_ok);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    tot_nxt = tot_r + 2'(in_acc && in_data.req_type == itaf_pkg::REQ_PIXEL)
                    - 2'(pkt_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= '0;
      tot_r       <= '0;
    end else begin
      tot_r <= tot_nxt;
      if (in_acc) begin
        cur_valid_r <= 1'b1;
        phase_r     <= '0;
      end else if (cur_done) begin
        cur_valid_r <= 1'b0;
      end else if (cur_valid_r) begin
        phase_r <= phase_r + itaf_pkg::PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r <= in_data;
    end
  end

  // Pixel code for the current phase
  always_comb begin
    unique case (phase_r)
      2'd0:    pix_sel = cur_r.pix0;
      2'd1:    pix_sel = cur_r.pix1;
      2'd2:    pix_sel = cur_r.pix2;
      2'd3:    pix_sel = cur_r.pix3;
      default: pix_sel = cur_r.pix0;
    endcase
  end

  assign rd_en   = cur_valid_r && cur_is_pix;
  assign rd_addr = {pix_sel[CODE_W-1:0], phase_r};

  // Row = (code, vector/4); segment = (vector%4)*2 + half; slot 3 never read
  assign wr_en   = cur_valid_r && !cur_is_pix &&
                   ({1'b0, cur_r.entry_pixel} < CODE_LIM) &&
                   (cur_r.entry_vector[1:0] != itaf_pkg::VEC_SLOT_UNUSED);
  assign wr_addr = {cur_r.entry_pixel[CODE_W-1:0], cur_r.entry_vector[3:2]};
  assign wr_seg  = {cur_r.entry_vector[1:0], cur_r.entry_half};

  always_comb begin
    for (int s = 0; s < itaf_pkg::SEGS; s++) begin
      wr_mask[s] = (wr_seg == itaf_pkg::SEG_W'(s));
    end
  end

  // Tag aligned with the registered read data; only valid is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= rd_en;
    end
    tag_r.phase <= phase_r;
    tag_r.zero  <= ({1'b0, pix_sel} >= CODE_LIM);
    tag_r.last  <= cur_r.last_group;
  end

  itaf_table #(
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_data (cur_r.entry_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  itaf_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag_r),
    .rd_data   (rd_data),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  itaf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pkt_valid),
    .push_pkt  (pkt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pkt_done  (pkt_done)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  itaf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  itaf_pkg::out_t out_data;

  impulse_table_accumulate_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: impulse table, write marks, and the two carried
  // accumulators (A0, A1). Expected output beats queue up in accept order.
  // ---------------------------------------------------------------------
  logic [63:0] shadow_table [0:8191];
  bit entry_written [0:8191];
  logic [itaf_pkg::LANES-1:0][15:0] acc_a0 = '0;
  logic [itaf_pkg::LANES-1:0][15:0] acc_a1 = '0;
  itaf_pkg::out_t pending_bytes[$];

  int errors = 0;
  int beats_sent = 0;
  bit idle_en = 1'b1;

  // Codes that have some phase rows loaded; random groups mostly draw here
  // so that deep carry chains form over known table contents.
  bit in_pool [0:255];
  logic [7:0] code_pool[$];

  // >>4 arithmetic, negative lanes go to 0, big ones clip at 255
  function automatic logic [7:0] clip_lane(input logic [15:0] x);
    logic [11:0] s;
    s = x[15:4];
    if (x[15]) return 8'd0;
    if (s > 12'd255) return 8'hFF;
    return s[7:0];
  endfunction

  function automatic logic [63:0] clip_bytes(
      input logic [itaf_pkg::LANES-1:0][15:0] acc);
    logic [63:0] r;
    for (int i = 0; i < itaf_pkg::LANES; i++) r[8*i +: 8] = clip_lane(acc[i]);
    return r;
  endfunction

  function automatic logic [15:0] lane_of(input logic [7:0] code, input int vec,
                                          input int lane);
    logic [12:0] idx;
    idx = {code, 4'(vec), 1'(lane >> 2)};
    return shadow_table[idx][16*(lane % 4) +: 16];
  endfunction

  // Advance the shadow by one accepted beat and queue the bytes it yields.
  task automatic filter_beat(input itaf_pkg::in_t b);
    logic [itaf_pkg::LANES-1:0][15:0] fresh;
    logic [3:0][7:0] codes;
    logic [12:0] idx;
    itaf_pkg::out_t r;
    if (b.req_type == itaf_pkg::REQ_WRITE) begin
      idx = {b.entry_pixel, b.entry_vector, b.entry_half};
      shadow_table[idx] = b.entry_data;
      entry_written[idx] = 1'b1;
    end else begin
      codes = {b.pix3, b.pix2, b.pix1, b.pix0};
      fresh = '0;
      for (int l = 0; l < itaf_pkg::LANES; l++) begin
        for (int k = 0; k < 4; k++) begin
          acc_a0[l] = acc_a0[l] + lane_of(codes[k], 4*k, l);
          acc_a1[l] = acc_a1[l] + lane_of(codes[k], 4*k + 1, l);
          fresh[l]  = fresh[l]  + lane_of(codes[k], 4*k + 2, l);
        end
      end
      r.out_bytes = clip_bytes(acc_a0);
      r.last_out = 1'b0;
      pending_bytes.push_back(r);
      acc_a0 = acc_a1;
      acc_a1 = fresh;
      if (b.last_group) begin
        // end of line: flush both carries, only the last beat is flagged
        r.out_bytes = clip_bytes(acc_a0);
        r.last_out = 1'b0;
        pending_bytes.push_back(r);
        r.out_bytes = clip_bytes(acc_a1);
        r.last_out = 1'b1;
        pending_bytes.push_back(r);
        acc_a0 = '0;
        acc_a1 = '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Beat builders. Fields the block ignores for a given request type are
  // still randomized so every bit toggles.
  // ---------------------------------------------------------------------
  function automatic logic [15:0] rand_lane();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(0, 400));
      5, 6:          return 16'(0 - int'($urandom_range(1, 400)));
      7:             return 16'($urandom_range(2048, 8191));
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_half();
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    return {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
  endfunction

  function automatic itaf_pkg::in_t table_beat(input logic [7:0] code,
                                               input logic [3:0] vec,
                                               input logic half,
                                               input logic [63:0] data);
    itaf_pkg::in_t b;
    b.req_type = itaf_pkg::REQ_WRITE;
    b.pix0 = 8'($urandom);
    b.pix1 = 8'($urandom);
    b.pix2 = 8'($urandom);
    b.pix3 = 8'($urandom);
    b.last_group = 1'($urandom);
    b.entry_pixel = code;
    b.entry_vector = vec;
    b.entry_half = half;
    b.entry_data = data;
    return b;
  endfunction

  function automatic itaf_pkg::in_t group_beat(input logic [7:0] p0,
                                               input logic [7:0] p1,
                                               input logic [7:0] p2,
                                               input logic [7:0] p3,
                                               input logic last);
    itaf_pkg::in_t b;
    b.req_type = itaf_pkg::REQ_PIXEL;
    b.pix0 = p0;
    b.pix1 = p1;
    b.pix2 = p2;
    b.pix3 = p3;
    b.last_group = last;
    b.entry_pixel = 8'($urandom);
    b.entry_vector = 4'($urandom);
    b.entry_half = 1'($urandom);
    b.entry_data = {$urandom, $urandom};
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // Sender. Entered right after an accept (or from idle); inputs move only
  // on the falling edge. valid is lowered only for a gap, so a back-to-back
  // beat never sees valid dropped and raised in one step.
  // ---------------------------------------------------------------------
  task automatic send_beat(input itaf_pkg::in_t b);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    filter_beat(b);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Load every half-vector that phase k of this code reads, if missing.
  task automatic load_phase(input logic [7:0] code, input int k);
    logic [12:0] idx;
    for (int v = 0; v < 3; v++) begin
      for (int h = 0; h < 2; h++) begin
        idx = {code, 4'(4*k + v), 1'(h)};
        if (!entry_written[idx]) send_beat(table_beat(code, 4'(4*k + v), 1'(h), rand_half()));
      end
    end
    if (!in_pool[code]) begin
      in_pool[code] = 1'b1;
      code_pool.push_back(code);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every beat taken off the output is matched against the
  // oldest prediction, field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin : check_beat
      itaf_pkg::out_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected beat out_bytes=%h last_out=%b",
                 $time, out_data.out_bytes, out_data.last_out);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.out_bytes !== want.out_bytes) begin
          $display("%0t: out_bytes expected %h actual %h",
                   $time, want.out_bytes, out_data.out_bytes);
          errors++;
        end
        if (out_data.last_out !== want.last_out) begin
          $display("%0t: last_out expected %b actual %b",
                   $time, want.last_out, out_data.last_out);
          errors++;
        end
      end
    end
  end

  // Receiver backpressure: random stall bursts, off in the tail.
  int stall_left = 0;
  always @(negedge clk) begin
    if (!idle_en) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[impulse_table_accumulate_filter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Codes 0x00 and 0xFF, all sixteen vectors, both halves. 0x00 is all zero;
  // 0xFF mixes lanes that clip high, go negative, and land mid-range.
  task automatic test_table_load();
    logic [63:0] d;
    for (int v = 0; v < 16; v++) begin
      for (int h = 0; h < 2; h++) begin
        send_beat(table_beat(8'h00, 4'(v), 1'(h), 64'h0));
        case (v % 4)
          0: d = h ? 64'h0000_0100_8000_FFFF : 64'h0003_7FFF_0040_0400;
          1: d = 64'hFFFF_FFFF_FFFF_FFFF;
          2: d = 64'h00F0_00F0_00F0_00F0;
          default: d = {$urandom, $urandom};
        endcase
        send_beat(table_beat(8'hFF, 4'(v), 1'(h), d));
      end
    end
    in_pool[8'h00] = 1'b1;
    in_pool[8'hFF] = 1'b1;
    code_pool.push_back(8'h00);
    code_pool.push_back(8'hFF);
  endtask

  task automatic test_directed_groups();
    send_beat(group_beat(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));  // all-zero row
    send_beat(group_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));  // clip and negative
    send_beat(group_beat(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
    send_beat(group_beat(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1));  // flush with carries
    send_beat(group_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));  // flush from cleared
    // write with stray pixel fields and last_group: no result
    send_beat(table_beat(8'h00, 4'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_beat(group_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_beat(group_beat(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    send_beat(group_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));  // back-to-back flushes
    send_beat(group_beat(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1));
    wait_drained();
  endtask

  // Mostly well-formed groups over loaded codes, with rewrites of live
  // entries and stray writes mixed in. With with_pause, one mid-stream pause
  // lets the block drain completely before the stream resumes.
  task automatic test_random_stream(input int n_items, input bit with_pause);
    int first;
    int pick;
    bit paused;
    logic [7:0] codes [4];
    first = beats_sent;
    paused = !with_pause;
    while (beats_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat(table_beat(code_pool[$urandom_range(0, code_pool.size() - 1)],
                             4'($urandom), 1'($urandom), rand_half()));
      end else if (pick < 12) begin
        send_beat(table_beat(8'($urandom), 4'($urandom), 1'($urandom),
                             {$urandom, $urandom}));
      end else begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 3) == 0)
            codes[k] = 8'($urandom);
          else
            codes[k] = code_pool[$urandom_range(0, code_pool.size() - 1)];
          load_phase(codes[k], k);
        end
        send_beat(group_beat(codes[0], codes[1], codes[2], codes[3],
                             $urandom_range(0, 4) == 0));
      end
      if (!paused && beats_sent - first >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Full rate on both sides to close the run.
  task automatic test_unthrottled_tail(input int n_items);
    idle_en = 1'b0;
    test_random_stream(n_items, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_table_load();
    test_directed_groups();
    test_random_stream(60, 1'b1);
    test_unthrottled_tail(24);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // catch any stray beats after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[impulse_table_accumulate_filter] OK");
    end else begin
      $display("[impulse_table_accumulate_filter] ERROR");
    end
    $finish;
  end

endmodule
